// File: hw/rtl/mesh_triangle_index_generator_defines.svh
// Assertion macros used by the mesh triangle index generator RTL.
`ifndef MESH_TRIANGLE_INDEX_GENERATOR_DEFINES_SVH
`define MESH_TRIANGLE_INDEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MTIG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MTIG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mtig_pkg.sv
// Types, codes and helpers for the mesh triangle index generator.
package mtig_pkg;

    localparam int MAX_QUADS = 1023;
    localparam int COUNT_W   = 10;
    localparam int INDEX_W   = 23;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [1:0] {
        SHAPE_PLANE    = 2'd0,
        SHAPE_CUBE     = 2'd1,
        SHAPE_CYLINDER = 2'd2,
        SHAPE_SPHERE   = 2'd3
    } shape_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_SECOND = 2'd2;

    localparam logic [1:0] SECTION_TOP    = 2'd0;
    localparam logic [1:0] SECTION_BOTTOM = 2'd1;
    localparam logic [1:0] SECTION_SIDE   = 2'd2;

    localparam logic [2:0] FACE_LAST = 3'd5;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [INDEX_W-1:0] index_t;

    typedef struct packed {
        logic   half;
        count_t col;
        count_t row;
    } grid_pos_t;

    typedef struct packed {
        grid_pos_t pos;
        logic      row_inc;
        logic      done;
    } grid_step_t;

    // One quad-half step over a rows x cols grid.
    function automatic grid_step_t grid_next(grid_pos_t p, count_t rows, count_t cols);
        grid_step_t r;
        r.pos     = p;
        r.row_inc = 1'b0;
        r.done    = 1'b0;
        if (!p.half) begin
            r.pos.half = 1'b1;
        end
        else begin
            r.pos.half = 1'b0;
            if (({1'b0, p.col} + 11'd1) < {1'b0, cols}) begin
                r.pos.col = p.col + count_t'(1);
            end
            else begin
                r.pos.col = '0;
                if (({1'b0, p.row} + 11'd1) < {1'b0, rows}) begin
                    r.pos.row = p.row + count_t'(1);
                    r.row_inc = 1'b1;
                end
                else begin
                    r.pos.row = '0;
                    r.done    = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/mtig_in_if.sv
// Request channel carrying the restart flag.
interface mtig_in_if;
    import mtig_pkg::*;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// File: hw/rtl/mtig_out_if.sv
// Result channel carrying one triangle.
interface mtig_out_if;
    import mtig_pkg::*;
    logic   valid;
    logic   ready;
    index_t vertex_a;
    index_t vertex_b;
    index_t vertex_c;
    logic   last_of_mesh;
    logic   config_error;

    modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                    output last_of_mesh, output config_error, input ready);
    modport sink (input valid, input vertex_a, input vertex_b, input vertex_c,
                  input last_of_mesh, input config_error, output ready);
endinterface

// File: hw/rtl/mesh_triangle_index_generator.sv
// Top level: triangle index generator for plane, cube, cylinder and sphere meshes.
// Usage:
//   Program shape_kind, count_first and count_second through the write port
//   (cfg_we, cfg_index, cfg_data) while no request is in flight; any write to
//   a listed register moves the position back to the first triangle.
//   Each request on in_ch yields exactly one triangle on out_ch. restart = 1
//   emits the first triangle of the mesh; restart = 0 emits the next one.
//   The last triangle carries last_of_mesh, and the next request starts over.
//   Invalid counts give config_error with zero indices.
// Timing:
//   An accepted request's triangle is written into the output register and
//   shown in the cycle after it is taken. Throughput is one triangle per cycle
//   while the receiver takes each result, set by the position counters and base adders.
//   A one-entry output register sits between the channels; in_ch.ready stays
//   high while that register is empty or being drained, so a stalled receiver
//   holds the result and blocks new requests only after one is waiting.
// Reset:
//   rst_n clears the position to the first triangle and restores the register
//   defaults: plane, one quad per edge. The output register comes up empty.
`include "mesh_triangle_index_generator_defines.svh"

module mesh_triangle_index_generator
    import mtig_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mtig_in_if.sink               in_ch,
    mtig_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    shape_t shape_reg;
    count_t count_first_reg;
    count_t count_second_reg;

    // position state
    logic [1:0] section_reg,     section_next;
    logic [2:0] face_number_reg, face_number_next;
    count_t     row_reg,         row_next;
    count_t     col_reg,         col_next;
    logic       half_reg,        half_next;
    index_t     row_base_reg,    row_base_next;
    index_t     face_offset_reg, face_offset_next;

    // output register
    logic   out_valid_reg;
    index_t va_reg, vb_reg, vc_reg;
    logic   last_reg, err_reg;

    logic   in_fire;
    logic   counts_bad;
    logic   last_w;
    index_t va_w, vb_w, vc_w;

    // effective position after restart
    logic [1:0] es_section;
    logic [2:0] es_face;
    grid_pos_t  es_pos;
    index_t     es_row_base, es_face_offset;

    count_t     grid_rows, grid_cols;
    grid_step_t g1, g2;

    logic [10:0] s11;
    logic [21:0] ss_prod;
    index_t      s_w, b_w, lid_w, col_w, q_w, jn_w;
    logic        col_wrap_ok;
    logic        start_half;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;

    assign start_half = (shape_reg == SHAPE_SPHERE);

    always_comb
    begin
        if (in_ch.restart) begin
            es_section     = SECTION_TOP;
            es_face        = '0;
            es_pos.half    = start_half;
            es_pos.col     = '0;
            es_pos.row     = '0;
            es_row_base    = '0;
            es_face_offset = '0;
        end
        else begin
            es_section     = section_reg;
            es_face        = face_number_reg;
            es_pos.half    = half_reg;
            es_pos.col     = col_reg;
            es_pos.row     = row_reg;
            es_row_base    = row_base_reg;
            es_face_offset = face_offset_reg;
        end
    end

    always_comb
    begin
        counts_bad = (count_first_reg == '0) ||
                     ({1'b0, count_first_reg} > 11'(MAX_QUADS));
        unique case (shape_reg)
            SHAPE_CYLINDER:
                counts_bad = counts_bad || (count_second_reg == '0) ||
                             ({1'b0, count_second_reg} > 11'(MAX_QUADS));
            SHAPE_SPHERE:
                counts_bad = counts_bad || (count_first_reg < count_t'(3)) ||
                             (count_second_reg < count_t'(2)) ||
                             ({1'b0, count_second_reg} > 11'(MAX_QUADS));
            default:
                counts_bad = counts_bad;
        endcase
    end

    assign s11     = {1'b0, count_first_reg} + 11'd1;
    assign ss_prod = {11'b0, s11} * {11'b0, s11};
    assign s_w     = INDEX_W'(s11);
    assign b_w     = INDEX_W'(count_second_reg);
    assign lid_w   = b_w + index_t'(1);
    assign col_w   = INDEX_W'(es_pos.col);
    assign q_w     = es_row_base + col_w;
    assign col_wrap_ok = ({1'b0, es_pos.col} + 11'd1) < {1'b0, count_second_reg};
    assign jn_w    = col_wrap_ok ? col_w + index_t'(1) : '0;

    // triangle of the current position
    always_comb
    begin
        va_w   = '0;
        vb_w   = '0;
        vc_w   = '0;
        last_w = 1'b0;
        unique case (shape_reg)
            SHAPE_PLANE, SHAPE_CUBE:
            begin
                if (!es_pos.half) begin
                    va_w = q_w;
                    vb_w = q_w + s_w;
                    vc_w = q_w + index_t'(1);
                end
                else begin
                    va_w = q_w + index_t'(1);
                    vb_w = q_w + s_w;
                    vc_w = q_w + s_w + index_t'(1);
                end
                last_w = (es_pos.row == count_first_reg - count_t'(1)) &&
                         (es_pos.col == count_first_reg - count_t'(1)) && es_pos.half &&
                         ((shape_reg == SHAPE_PLANE) || (es_face == FACE_LAST));
            end
            SHAPE_CYLINDER:
            begin
                if (es_section == SECTION_TOP) begin
                    va_w = '0;
                    vb_w = col_wrap_ok ? col_w + index_t'(2) : index_t'(1);
                    vc_w = col_w + index_t'(1);
                end
                else if (es_section == SECTION_BOTTOM) begin
                    va_w = lid_w;
                    vb_w = lid_w + col_w + index_t'(1);
                    vc_w = col_wrap_ok ? lid_w + col_w + index_t'(2) : lid_w + index_t'(1);
                end
                else begin
                    va_w = es_row_base + col_w;
                    if (!es_pos.half) begin
                        vb_w = es_row_base + b_w + jn_w;
                        vc_w = es_row_base + b_w + col_w;
                    end
                    else begin
                        vb_w = es_row_base + jn_w;
                        vc_w = es_row_base + b_w + jn_w;
                    end
                    last_w = (es_pos.row == count_first_reg - count_t'(1)) &&
                             (es_pos.col == count_second_reg - count_t'(1)) && es_pos.half;
                end
            end
            SHAPE_SPHERE:
            begin
                if (!es_pos.half) begin
                    va_w = q_w;
                    vb_w = q_w + index_t'(1);
                    vc_w = q_w + s_w;
                end
                else begin
                    va_w = q_w + index_t'(1);
                    vb_w = q_w + s_w + index_t'(1);
                    vc_w = q_w + s_w;
                end
                last_w = (es_pos.row == count_second_reg - count_t'(1)) &&
                         (es_pos.col == count_first_reg - count_t'(1)) && !es_pos.half;
            end
            default:
            begin
                va_w = '0;
            end
        endcase
    end

    always_comb
    begin
        if (shape_reg == SHAPE_CYLINDER) begin
            grid_rows = count_first_reg;
            grid_cols = count_second_reg;
        end
        else if (shape_reg == SHAPE_SPHERE) begin
            grid_rows = count_second_reg;
            grid_cols = count_first_reg;
        end
        else begin
            grid_rows = count_first_reg;
            grid_cols = count_first_reg;
        end
        g1 = grid_next(es_pos, grid_rows, grid_cols);
        g2 = grid_next(g1.pos, grid_rows, grid_cols);
    end

    // position after this triangle
    always_comb
    begin
        section_next     = es_section;
        face_number_next = es_face;
        row_next         = es_pos.row;
        col_next         = es_pos.col;
        half_next        = es_pos.half;
        row_base_next    = es_row_base;
        face_offset_next = es_face_offset;
        if (counts_bad || last_w) begin
            section_next     = SECTION_TOP;
            face_number_next = '0;
            row_next         = '0;
            col_next         = '0;
            half_next        = start_half;
            row_base_next    = '0;
            face_offset_next = '0;
        end
        else begin
            unique case (shape_reg)
                SHAPE_PLANE, SHAPE_CUBE:
                begin
                    row_next  = g1.pos.row;
                    col_next  = g1.pos.col;
                    half_next = g1.pos.half;
                    if (g1.done) begin
                        if (shape_reg == SHAPE_CUBE && es_face != FACE_LAST) begin
                            face_number_next = es_face + 3'd1;
                            face_offset_next = es_face_offset + INDEX_W'(ss_prod);
                        end
                        else begin
                            face_number_next = '0;
                            face_offset_next = '0;
                        end
                        row_base_next = face_offset_next;
                    end
                    else if (g1.row_inc) begin
                        row_base_next = es_row_base + s_w;
                    end
                end
                SHAPE_CYLINDER:
                begin
                    if (es_section == SECTION_TOP || es_section == SECTION_BOTTOM) begin
                        if (col_wrap_ok) begin
                            col_next = es_pos.col + count_t'(1);
                        end
                        else begin
                            col_next     = '0;
                            section_next = es_section + 2'd1;
                            face_offset_next = (es_section == SECTION_TOP) ? lid_w
                                                                           : lid_w + lid_w;
                            row_base_next = face_offset_next;
                        end
                    end
                    else begin
                        row_next  = g1.pos.row;
                        col_next  = g1.pos.col;
                        half_next = g1.pos.half;
                        if (g1.done) begin
                            row_base_next = es_face_offset;
                        end
                        else if (g1.row_inc) begin
                            row_base_next = es_row_base + b_w;
                        end
                    end
                end
                SHAPE_SPHERE:
                begin
                    row_next  = g1.pos.row;
                    col_next  = g1.pos.col;
                    half_next = g1.pos.half;
                    if (g1.done) begin
                        row_base_next = '0;
                    end
                    else if (g1.row_inc) begin
                        row_base_next = es_row_base + s_w;
                    end
                    // skip the degenerate pole halves
                    if (g1.pos.row == '0 && !g1.pos.half) begin
                        half_next = 1'b1;
                    end
                    else if (g1.pos.row == count_second_reg - count_t'(1) && g1.pos.half) begin
                        row_next  = g2.pos.row;
                        col_next  = g2.pos.col;
                        half_next = g2.pos.half;
                        if (g2.done) begin
                            row_base_next = '0;
                        end
                        else if (g2.row_inc) begin
                            row_base_next = es_row_base + s_w;
                        end
                    end
                end
                default:
                begin
                    half_next = es_pos.half;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            shape_reg        <= SHAPE_PLANE;
            count_first_reg  <= count_t'(1);
            count_second_reg <= count_t'(1);
            section_reg      <= SECTION_TOP;
            face_number_reg  <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            half_reg         <= 1'b0;
            row_base_reg     <= '0;
            face_offset_reg  <= '0;
        end
        else if (cfg_we && (cfg_index == CFG_SHAPE_KIND || cfg_index == CFG_COUNT_FIRST ||
                            cfg_index == CFG_COUNT_SECOND)) begin
            // any listed write returns to the first triangle
            section_reg     <= SECTION_TOP;
            face_number_reg <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            row_base_reg    <= '0;
            face_offset_reg <= '0;
            half_reg        <= (cfg_index == CFG_SHAPE_KIND) ?
                               (shape_t'(cfg_data[1:0]) == SHAPE_SPHERE) : start_half;
            unique case (cfg_index)
                CFG_SHAPE_KIND:   shape_reg        <= shape_t'(cfg_data[1:0]);
                CFG_COUNT_FIRST:  count_first_reg  <= cfg_data;
                CFG_COUNT_SECOND: count_second_reg <= cfg_data;
                default:          shape_reg        <= shape_reg;
            endcase
        end
        else if (in_fire) begin
            section_reg     <= section_next;
            face_number_reg <= face_number_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            half_reg        <= half_next;
            row_base_reg    <= row_base_next;
            face_offset_reg <= face_offset_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the payload until the next request is taken
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            va_reg   <= counts_bad ? '0 : va_w;
            vb_reg   <= counts_bad ? '0 : vb_w;
            vc_reg   <= counts_bad ? '0 : vc_w;
            last_reg <= !counts_bad && last_w;
            err_reg  <= counts_bad;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.vertex_a     = va_reg;
    assign out_ch.vertex_b     = vb_reg;
    assign out_ch.vertex_c     = vc_reg;
    assign out_ch.last_of_mesh = last_reg;
    assign out_ch.config_error = err_reg;

    `MTIG_ASSERT_NEXT(a_fire_fills_output, in_fire, out_valid_reg,
                      "accepted request did not fill the output register")
    `MTIG_ASSERT_NOW(a_no_overwrite, out_valid_reg && !out_ch.ready, !in_ch.ready,
                     "request accepted while the result is stalled")
    `MTIG_ASSERT_NEXT(a_last_restarts, in_fire && last_w && !counts_bad && !cfg_we,
                      row_reg == '0 && col_reg == '0 && face_number_reg == '0 &&
                      section_reg == SECTION_TOP && row_base_reg == '0,
                      "position not back at start after last triangle")
    `MTIG_ASSERT_NOW(a_face_range, 1'b1, face_number_reg <= FACE_LAST,
                     "cube face counter out of range")
    `MTIG_ASSERT_NOW(a_error_clean, out_valid_reg && err_reg,
                     va_reg == '0 && vb_reg == '0 && vc_reg == '0 && !last_reg,
                     "error result carries nonzero fields")

endmodule

// File: tb/sv/mtig_triangle_checker.sv
`timescale 1ns / 1ps
// Checker for the mesh triangle index generator: predicts each triangle and compares results.
module mtig_triangle_checker
    import mtig_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mtig_in_if                    in_ch,
    mtig_out_if                   out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int unsigned CUBE_FACES = 6;
    localparam int          MAX_REPORTS = 40;

    typedef struct packed {
        index_t a;
        index_t b;
        index_t c;
        logic   last;
        logic   err;
    } triangle_t;

    triangle_t expected_tris[$];

    // Register copies and mesh position.
    shape_t      shape;
    int unsigned first_count;
    int unsigned second_count;
    int unsigned part;
    int unsigned face;
    int unsigned row;
    int unsigned col;
    bit          upper;
    int unsigned row_base;
    int unsigned face_base;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic bit counts_invalid();
        if (first_count == 0)
        begin
            return 1'b1;
        end
        case (shape)
            SHAPE_CYLINDER: return second_count == 0;
            SHAPE_SPHERE:   return first_count < 3 || second_count < 2;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic void refresh_bases();
        int unsigned stride;
        stride = first_count + 1;
        case (shape)
            SHAPE_CUBE:
                face_base = face * stride * stride;
            SHAPE_CYLINDER:
                face_base = (part == SECTION_BOTTOM) ? second_count + 1 :
                            (part == SECTION_SIDE) ? 2 * (second_count + 1) : 0;
            default:
                face_base = 0;
        endcase
        if (shape == SHAPE_CYLINDER)
        begin
            row_base = face_base + row * second_count;
        end
        else
        begin
            row_base = face_base + row * stride;
        end
    endfunction

    function automatic void rewind();
        part  = SECTION_TOP;
        face  = 0;
        row   = 0;
        col   = 0;
        // sphere starts on the upper half, the first row has no lower triangle
        upper = (shape == SHAPE_SPHERE);
        refresh_bases();
    endfunction

    // Step one quad half over a rows x cols grid; true when the grid wraps.
    function automatic bit step_grid(input int unsigned rows, input int unsigned cols);
        if (!upper)
        begin
            upper = 1'b1;
            return 1'b0;
        end
        upper = 1'b0;
        if (col + 1 < cols)
        begin
            col++;
            return 1'b0;
        end
        col = 0;
        if (row + 1 < rows)
        begin
            row++;
            return 1'b0;
        end
        row = 0;
        return 1'b1;
    endfunction

    function automatic void advance_position();
        case (shape)
            SHAPE_PLANE:
                void'(step_grid(first_count, first_count));
            SHAPE_CUBE:
                if (step_grid(first_count, first_count))
                begin
                    face = (face + 1) % CUBE_FACES;
                end
            SHAPE_CYLINDER:
                if (part < SECTION_SIDE)
                begin
                    if (col + 1 < second_count)
                    begin
                        col++;
                    end
                    else
                    begin
                        col = 0;
                        part++;
                    end
                end
                else
                begin
                    void'(step_grid(first_count, second_count));
                end
            default:
            begin
                // skip the degenerate pole triangles
                void'(step_grid(second_count, first_count));
                if (row == 0 && !upper)
                begin
                    upper = 1'b1;
                end
                else if (row == second_count - 1 && upper)
                begin
                    void'(step_grid(second_count, first_count));
                end
            end
        endcase
        refresh_bases();
    endfunction

    function automatic triangle_t next_triangle(input logic restart);
        triangle_t   t;
        int unsigned v0, v1, v2;
        int unsigned stride, q, lid, jn, i0, i1, i2, i3;
        bit          last;
        t = '0;
        if (restart)
        begin
            rewind();
        end
        if (counts_invalid())
        begin
            rewind();
            t.err = 1'b1;
            return t;
        end
        v0     = 0;
        v1     = 0;
        v2     = 0;
        last   = 1'b0;
        stride = first_count + 1;
        q      = row_base + col;
        case (shape)
            SHAPE_PLANE, SHAPE_CUBE:
            begin
                if (!upper)
                begin
                    v0 = q;
                    v1 = q + stride;
                    v2 = q + 1;
                end
                else
                begin
                    v0 = q + 1;
                    v1 = q + stride;
                    v2 = q + stride + 1;
                end
                last = row == first_count - 1 && col == first_count - 1 && upper &&
                       (shape == SHAPE_PLANE || face == FACE_LAST);
            end
            SHAPE_CYLINDER:
            begin
                lid = second_count + 1;
                if (part == SECTION_TOP)
                begin
                    v0 = 0;
                    v1 = (col + 1 < second_count) ? col + 2 : 1;
                    v2 = col + 1;
                end
                else if (part == SECTION_BOTTOM)
                begin
                    v0 = lid;
                    v1 = lid + col + 1;
                    v2 = (col + 1 < second_count) ? lid + col + 2 : lid + 1;
                end
                else
                begin
                    // side columns wrap back to the first one
                    jn = (col + 1 < second_count) ? col + 1 : 0;
                    i0 = row_base + col;
                    i1 = row_base + second_count + col;
                    i2 = row_base + jn;
                    i3 = row_base + second_count + jn;
                    if (!upper)
                    begin
                        v0 = i0;
                        v1 = i3;
                        v2 = i1;
                    end
                    else
                    begin
                        v0 = i0;
                        v1 = i2;
                        v2 = i3;
                    end
                    last = row == first_count - 1 && col == second_count - 1 && upper;
                end
            end
            default:
            begin
                if (!upper)
                begin
                    v0 = q;
                    v1 = q + 1;
                    v2 = q + stride;
                end
                else
                begin
                    v0 = q + 1;
                    v1 = q + stride + 1;
                    v2 = q + stride;
                end
                last = row == second_count - 1 && col == first_count - 1 && !upper;
            end
        endcase
        if (last)
        begin
            rewind();
        end
        else
        begin
            advance_position();
        end
        t.a    = index_t'(v0);
        t.b    = index_t'(v1);
        t.c    = index_t'(v2);
        t.last = last;
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        triangle_t got;
        triangle_t want;
        if (!rst_n)
        begin
            shape        = SHAPE_PLANE;
            first_count  = 1;
            second_count = 1;
            fail_count   = 0;
            rewind();
            expected_tris.delete();
            pending <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.a    = out_ch.vertex_a;
                got.b    = out_ch.vertex_b;
                got.c    = out_ch.vertex_c;
                got.last = out_ch.last_of_mesh;
                got.err  = out_ch.config_error;
                if (expected_tris.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected triangle %0d %0d %0d",
                                              got.a, got.b, got.c));
                end
                else
                begin
                    want = expected_tris.pop_front();
                    if (got.a !== want.a)
                        report_mismatch($sformatf("vertex_a %0h, want %0h", got.a, want.a));
                    if (got.b !== want.b)
                        report_mismatch($sformatf("vertex_b %0h, want %0h", got.b, want.b));
                    if (got.c !== want.c)
                        report_mismatch($sformatf("vertex_c %0h, want %0h", got.c, want.c));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last_of_mesh %b, want %b",
                                                  got.last, want.last));
                    if (got.err !== want.err)
                        report_mismatch($sformatf("config_error %b, want %b",
                                                  got.err, want.err));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SHAPE_KIND:
                    begin
                        shape = shape_t'(cfg_data[1:0]);
                        rewind();
                    end
                    CFG_COUNT_FIRST:
                    begin
                        first_count = cfg_data;
                        rewind();
                    end
                    CFG_COUNT_SECOND:
                    begin
                        second_count = cfg_data;
                        rewind();
                    end
                    default:
                        ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_tris.push_back(next_triangle(in_ch.restart));
            end
            pending <= expected_tris.size();
        end
    end

endmodule

// File: tb/sv/tb_mesh_triangle_index_generator.sv
`timescale 1ns / 1ps
// Testbench top for the mesh triangle index generator: stimulus, receiver and verdict.
module tb_mesh_triangle_index_generator;
    import mtig_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_PCT     = 8;
    localparam int RESTART_PCT  = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 900;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    bit steady;
    bit hold_toggle;
    int requests_sent;
    int settings_used;
    int holds_done;

    mtig_in_if  in_ch();
    mtig_out_if out_ch();

    mesh_triangle_index_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mtig_triangle_checker tri_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    task automatic send_request(input logic restart);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    // Drop valid and hold until every predicted triangle has come back.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic configure(input shape_t shape, input int first_count, input int second_count);
        logic [CFG_DATA_W-1:0] shape_word;
        wait_idle();
        shape_word      = CFG_DATA_W'($urandom);
        shape_word[1:0] = shape;
        write_reg(CFG_SHAPE_KIND, shape_word);
        if ($urandom_range(3) == 0)
        begin
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        end
        write_reg(CFG_COUNT_FIRST, CFG_DATA_W'(first_count));
        write_reg(CFG_COUNT_SECOND, CFG_DATA_W'(second_count));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 5)
        begin
            return 0;
        end
        if (r < 10)
        begin
            return 1023;
        end
        if (r < 16)
        begin
            return $urandom_range(1023);
        end
        return $urandom_range(1, 3);
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked.
    initial
    begin : receiver
        bit seen;
        seen = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (seen != hold_toggle)
            begin
                seen = hold_toggle;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin : watchdog
        int stall;
        stall = 0;
        @(posedge rst_n);
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall = 0;
            else
                stall++;
        end
        $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int     phase;
        int     base_count;
        int     mesh_len;
        int     n;
        int     first_count;
        int     second_count;
        shape_t shape;

        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.restart <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_SHAPE_KIND;
        cfg_data      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: plane of one quad, wraps after two triangles
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        configure(SHAPE_PLANE, 0, 5);
        send_request(1'b0);
        configure(SHAPE_SPHERE, 2, 5);
        send_request(1'b0);
        configure(SHAPE_SPHERE, 3, 1);
        send_request(1'b1);
        configure(SHAPE_SPHERE, 3, 2);
        repeat (4) send_request(1'b0);
        configure(SHAPE_CYLINDER, 4, 0);
        send_request(1'b0);
        configure(SHAPE_CYLINDER, 1023, 1023);
        repeat (2) send_request(1'b0);
        configure(SHAPE_CUBE, 1023, 0);
        send_request(1'b0);
        send_request(1'b1);
        configure(SHAPE_PLANE, 1023, 1023);
        repeat (2) send_request(1'b0);
        configure(SHAPE_SPHERE, 1023, 1023);
        send_request(1'b0);
        // a write to the unused index must leave the position alone
        wait_idle();
        write_reg(CFG_UNUSED, '1);
        cfg_we <= 1'b0;
        send_request(1'b0);

        phase      = 0;
        base_count = requests_sent;
        while (requests_sent - base_count < RANDOM_ITEMS)
        begin
            shape        = shape_t'($urandom_range(3));
            first_count  = pick_count();
            second_count = pick_count();
            if (shape == SHAPE_SPHERE && $urandom_range(99) < 70)
            begin
                first_count  = $urandom_range(3, 4);
                second_count = $urandom_range(2, 3);
            end
            configure(shape, first_count, second_count);
            case (shape)
                SHAPE_PLANE:    mesh_len = 2 * first_count * first_count;
                SHAPE_CUBE:     mesh_len = 12 * first_count * first_count;
                SHAPE_CYLINDER: mesh_len = 2 * second_count + 2 * first_count * second_count;
                default:        mesh_len = 2 * first_count * second_count - 2 * first_count;
            endcase
            if (mesh_len >= 1 && mesh_len <= 120)
                n = mesh_len + $urandom_range(mesh_len);
            else
                n = $urandom_range(10, 40);
            steady = (phase >= 4 && phase < 8);
            if (phase == 2)
            begin
                hold_toggle = ~hold_toggle;
                holds_done++;
                n += 40;
            end
            repeat (n) send_request($urandom_range(99) < RESTART_PCT);
            phase++;
        end

        wait_idle();
        repeat (4) @(posedge clk);
        $display("summary: %0d requests over %0d register settings, all four shapes",
                 requests_sent, settings_used);
        $display("summary: counts 0 to 1023, %0d long receiver hold-off(s), %0d mismatches",
                 holds_done, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mtig_pkg.sv
hw/rtl/mtig_in_if.sv
hw/rtl/mtig_out_if.sv
hw/rtl/mesh_triangle_index_generator.sv
tb/sv/mtig_triangle_checker.sv
tb/sv/tb_mesh_triangle_index_generator.sv
